// ===== rtl/bis_pkg.sv =====
// Shared types and constants of the bilinear image scaler.
package bis_pkg;

    localparam int COORD_W     = 10;
    localparam int PIX_W       = 16;
    localparam int SRC_DIM_W   = 9;
    localparam int TGT_DIM_W   = 11;
    localparam int STEP_W      = 25;
    localparam int CFG_DATA_W  = 25;
    localparam int CFG_INDEX_W = 3;
    localparam int FRAC_W      = 16;
    localparam int WEIGHT_W    = 17;
    localparam int PROD_W      = COORD_W + 1 + STEP_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_WIDTH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_HEIGHT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_HORIZONTAL = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_VERTICAL   = 3'd5;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_meta;

    typedef struct packed {
        logic              valid;
        t_meta             meta;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
    } t_blend_req;

endpackage

// ===== rtl/bis_in_if.sv =====
// Request channel of the bilinear image scaler.
interface bis_in_if;
    import bis_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [COORD_W-1:0]        column;
    logic [COORD_W-1:0]        row;
    logic signed [PIX_W-1:0]   pixel_in;
    modport source (output valid, kind, column, row, pixel_in, input ready);
    modport sink   (input valid, kind, column, row, pixel_in, output ready);
endinterface

// ===== rtl/bis_out_if.sv =====
// Result channel of the bilinear image scaler.
interface bis_out_if;
    import bis_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [COORD_W-1:0]        out_column;
    logic [COORD_W-1:0]        out_row;
    logic signed [PIX_W-1:0]   pixel_out;
    modport source (output valid, out_column, out_row, pixel_out, input ready);
    modport sink   (input valid, out_column, out_row, pixel_out, output ready);
endinterface

// ===== rtl/bis_locate.sv =====
// Maps an output coordinate to two clamped source indices and a weight.
module bis_locate #(
    parameter int SIZE_MAX = 256
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [bis_pkg::COORD_W-1:0]        i_coord,
    input  logic [bis_pkg::STEP_W-1:0]         i_step,
    input  logic [bis_pkg::SRC_DIM_W-1:0]      i_size,
    output logic [$clog2(SIZE_MAX)-1:0]        o_lo,
    output logic [$clog2(SIZE_MAX)-1:0]        o_hi,
    output logic [bis_pkg::FRAC_W-1:0]         o_frac
);
    import bis_pkg::*;

    localparam int IW = $clog2(SIZE_MAX);

    logic [PROD_W-1:0]        r_prod;
    logic [PROD_W-1:0]        pos;
    logic [PROD_W-FRAC_W-1:0] ipart;
    logic [31:0]              size_lim;
    logic [31:0]              last;
    logic [31:0]              ip32;
    logic [31:0]              n_lo;
    logic [31:0]              n_hi;

    always_comb begin
        if (i_size == '0) begin
            size_lim = 32'd1;
        end else if (32'(i_size) > 32'(SIZE_MAX)) begin
            size_lim = 32'(SIZE_MAX);
        end else begin
            size_lim = 32'(i_size);
        end
        last  = size_lim - 32'd1;
        // Position plus one pixel, so the integer part is never negative.
        pos   = (r_prod >> 1) + PROD_W'(32768);
        ipart = pos[PROD_W-1:FRAC_W];
        ip32  = 32'(ipart);
        n_hi  = (ip32 > last) ? last : ip32;
        if (ip32 == 32'd0) begin
            n_lo = 32'd0;
        end else begin
            n_lo = ((ip32 - 32'd1) > last) ? last : (ip32 - 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'({i_coord, 1'b1}) * PROD_W'(i_step);
            o_lo   <= n_lo[IW-1:0];
            o_hi   <= n_hi[IW-1:0];
            o_frac <= pos[FRAC_W-1:0];
        end
    end

endmodule

// ===== rtl/bis_store.sv =====
// Source pixel store, four banks split by row and column parity.
module bis_store #(
    parameter int MAX_W = 256,
    parameter int MAX_H = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic                                 i_wr,
    input  logic [$clog2(MAX_W)-1:0]             i_wr_col,
    input  logic [$clog2(MAX_H)-1:0]             i_wr_row,
    input  logic signed [bis_pkg::PIX_W-1:0]     i_wr_data,
    input  logic [$clog2(MAX_W)-1:0]             i_x_lo,
    input  logic [$clog2(MAX_W)-1:0]             i_x_hi,
    input  logic [$clog2(MAX_H)-1:0]             i_y_lo,
    input  logic [$clog2(MAX_H)-1:0]             i_y_hi,
    output logic [3:0][bis_pkg::PIX_W-1:0]       o_texel
);
    import bis_pkg::*;

    localparam int XW     = $clog2(MAX_W);
    localparam int YW     = $clog2(MAX_H);
    localparam int HALF_W = (MAX_W + 1) / 2;
    localparam int HALF_H = (MAX_H + 1) / 2;
    localparam int DEPTH  = HALF_W * HALF_H;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PIX_W-1:0] r_q [2][2];
    logic             r_xp_lo, r_xp_hi, r_yp_lo, r_yp_hi;

    for (genvar pr = 0; pr < 2; pr++) begin : g_row
        for (genvar pc = 0; pc < 2; pc++) begin : g_col
            logic [PIX_W-1:0] mem [DEPTH];
            logic [XW-1:0]    col_sel;
            logic [YW-1:0]    row_sel;
            logic [31:0]      raddr;
            logic [31:0]      waddr;
            logic [AW-1:0]    addr;
            logic             wsel;

            always_comb begin
                col_sel = (i_x_lo[0] == 1'(pc)) ? i_x_lo : i_x_hi;
                row_sel = (i_y_lo[0] == 1'(pr)) ? i_y_lo : i_y_hi;
                raddr   = 32'(row_sel >> 1) * 32'(HALF_W) + 32'(col_sel >> 1);
                waddr   = 32'(i_wr_row >> 1) * 32'(HALF_W) + 32'(i_wr_col >> 1);
                wsel    = i_wr && (i_wr_row[0] == 1'(pr)) && (i_wr_col[0] == 1'(pc));
                addr    = i_wr ? waddr[AW-1:0] : raddr[AW-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (wsel) begin
                        mem[addr] <= i_wr_data;
                    end else begin
                        r_q[pr][pc] <= mem[addr];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xp_lo <= i_x_lo[0];
            r_xp_hi <= i_x_hi[0];
            r_yp_lo <= i_y_lo[0];
            r_yp_hi <= i_y_hi[0];
        end
    end

    assign o_texel[0] = r_q[r_yp_lo][r_xp_lo];
    assign o_texel[1] = r_q[r_yp_lo][r_xp_hi];
    assign o_texel[2] = r_q[r_yp_hi][r_xp_lo];
    assign o_texel[3] = r_q[r_yp_hi][r_xp_hi];

endmodule

// ===== rtl/bis_blend.sv =====
// Weighted sum of four texels with rounding, output register included.
module bis_blend (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  bis_pkg::t_blend_req                  i_req,
    input  logic [3:0][bis_pkg::PIX_W-1:0]       i_texel,
    output logic                                 o_valid,
    output bis_pkg::t_meta                       o_meta,
    output logic signed [bis_pkg::PIX_W-1:0]     o_pixel
);
    import bis_pkg::*;

    localparam int PA_W = PIX_W + WEIGHT_W + 1;
    localparam int H_W  = PA_W + 1;
    localparam int V_W  = H_W + WEIGHT_W + 1;
    localparam int S_W  = V_W + 1;
    localparam int Q_W  = S_W - 32;

    logic [WEIGHT_W-1:0]     wx0, wx1, wy0, wy1;
    logic signed [PA_W-1:0]  r_pa [4];
    logic signed [H_W-1:0]   r_h0, r_h1;
    logic signed [V_W-1:0]   r_v0, r_v1;
    logic [FRAC_W-1:0]       r_fy_a, r_fy_b;
    t_meta                   r_meta_a, r_meta_b, r_meta_c;
    logic                    r_valid_a, r_valid_b, r_valid_c;
    logic signed [S_W-1:0]   sum;
    logic signed [Q_W-1:0]   quo;
    logic signed [PIX_W-1:0] n_pixel;

    always_comb begin
        wx1 = WEIGHT_W'(i_req.fx);
        wx0 = WEIGHT_ONE - wx1;
        wy1 = WEIGHT_W'(r_fy_b);
        wy0 = WEIGHT_ONE - wy1;
        // Half an output step is added so the shift rounds to nearest.
        sum = S_W'(r_v0) + S_W'(r_v1) + (S_W'(1) <<< 31);
        quo = Q_W'(sum >>> 32);
        if (quo > Q_W'(32767)) begin
            n_pixel = 16'sh7FFF;
        end else if (quo < -Q_W'(32768)) begin
            n_pixel = 16'sh8000;
        end else begin
            n_pixel = quo[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
            r_valid_c <= 1'b0;
            o_valid   <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_req.valid;
            r_valid_b <= r_valid_a;
            r_valid_c <= r_valid_b;
            o_valid   <= r_valid_c;
        end
        if (i_en) begin
            r_pa[0]  <= $signed(i_texel[0]) * $signed({1'b0, wx0});
            r_pa[1]  <= $signed(i_texel[1]) * $signed({1'b0, wx1});
            r_pa[2]  <= $signed(i_texel[2]) * $signed({1'b0, wx0});
            r_pa[3]  <= $signed(i_texel[3]) * $signed({1'b0, wx1});
            r_fy_a   <= i_req.fy;
            r_meta_a <= i_req.meta;
            r_h0     <= H_W'(r_pa[0]) + H_W'(r_pa[1]);
            r_h1     <= H_W'(r_pa[2]) + H_W'(r_pa[3]);
            r_fy_b   <= r_fy_a;
            r_meta_b <= r_meta_a;
            r_v0     <= r_h0 * $signed({1'b0, wy0});
            r_v1     <= r_h1 * $signed({1'b0, wy1});
            r_meta_c <= r_meta_b;
            o_meta   <= r_meta_c;
            o_pixel  <= n_pixel;
        end
    end

endmodule

// ===== rtl/bilinear_image_scaler.sv =====
// Top level of the bilinear image scaler.
// Requests arrive on i_req: kind KIND_WRITE stores pixel_in at (column, row) of the
// source image, kind KIND_SAMPLE asks for output pixel (column, row). Each sample
// inside the target size gives one result on o_rsp with its coordinates and the
// interpolated pixel; writes and samples outside the target give nothing.
// Registers are written through i_cfg_we, i_cfg_index and i_cfg_data. The user
// must write them only while the block is idle; the block does not enforce this.
// One request is taken every cycle while the receiver does not stall. A result
// passes registered coordinate mapping, a store read, then multiply, add and round.
// The store has four single-port banks by row and column parity, so the four
// neighbors of a sample are read in the same cycle, and a write passes the store
// at the same stage as a read, which keeps request order.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// i_req.ready goes low. Reset loads the default register values and empties the
// pipeline; the store content is undefined until written.
module bilinear_image_scaler #(
    parameter int MAX_SOURCE_WIDTH  = 256,
    parameter int MAX_SOURCE_HEIGHT = 256,
    parameter int MAX_TARGET_DIM    = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bis_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    bis_in_if.sink                               i_req,
    bis_out_if.source                            o_rsp
);
    import bis_pkg::*;

    localparam int XW = $clog2(MAX_SOURCE_WIDTH);
    localparam int YW = $clog2(MAX_SOURCE_HEIGHT);

    logic [SRC_DIM_W-1:0] r_source_width, r_source_height;
    logic [TGT_DIM_W-1:0] r_target_width, r_target_height;
    logic [STEP_W-1:0]    r_step_horizontal, r_step_vertical;

    logic                 en, accept, in_target;
    logic [31:0]          tw_lim, th_lim, wc32, wr32;
    logic                 r_s0_valid, r_s1_valid;
    logic                 r_s0_kind, r_s1_kind;
    t_meta                r_s0_meta, r_s1_meta;
    logic [PIX_W-1:0]     r_s0_pix, r_s1_pix;
    logic                 wr_ok;
    logic [XW-1:0]        x_lo, x_hi;
    logic [YW-1:0]        y_lo, y_hi;
    logic [FRAC_W-1:0]    fx, fy;
    t_blend_req           r_s2_req;
    logic [3:0][PIX_W-1:0] texel;
    logic                 out_valid;
    t_meta                out_meta;
    logic signed [PIX_W-1:0] out_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width    <= SRC_DIM_W'(256);
            r_source_height   <= SRC_DIM_W'(256);
            r_target_width    <= TGT_DIM_W'(256);
            r_target_height   <= TGT_DIM_W'(256);
            r_step_horizontal <= STEP_W'(65536);
            r_step_vertical   <= STEP_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SOURCE_WIDTH:    r_source_width    <= i_cfg_data[SRC_DIM_W-1:0];
                CFG_SOURCE_HEIGHT:   r_source_height   <= i_cfg_data[SRC_DIM_W-1:0];
                CFG_TARGET_WIDTH:    r_target_width    <= i_cfg_data[TGT_DIM_W-1:0];
                CFG_TARGET_HEIGHT:   r_target_height   <= i_cfg_data[TGT_DIM_W-1:0];
                CFG_STEP_HORIZONTAL: r_step_horizontal <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_VERTICAL:   r_step_vertical   <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign en          = !out_valid || o_rsp.ready;
    assign i_req.ready = en;
    assign accept      = i_req.valid && en;

    always_comb begin
        tw_lim = (32'(r_target_width) > 32'(MAX_TARGET_DIM)) ?
                 32'(MAX_TARGET_DIM) : 32'(r_target_width);
        th_lim = (32'(r_target_height) > 32'(MAX_TARGET_DIM)) ?
                 32'(MAX_TARGET_DIM) : 32'(r_target_height);
        in_target = (32'(i_req.column) < tw_lim) && (32'(i_req.row) < th_lim);
        wc32  = 32'(r_s1_meta.column);
        wr32  = 32'(r_s1_meta.row);
        wr_ok = r_s1_valid && (r_s1_kind == KIND_WRITE) &&
                (wc32 < 32'(MAX_SOURCE_WIDTH)) && (wr32 < 32'(MAX_SOURCE_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid     <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_s2_req.valid <= 1'b0;
        end else if (en) begin
            r_s0_valid     <= accept && ((i_req.kind == KIND_WRITE) || in_target);
            r_s1_valid     <= r_s0_valid;
            r_s2_req.valid <= r_s1_valid && (r_s1_kind == KIND_SAMPLE);
        end
        if (en) begin
            r_s0_kind        <= i_req.kind;
            r_s0_meta.column <= i_req.column;
            r_s0_meta.row    <= i_req.row;
            r_s0_pix         <= i_req.pixel_in;
            r_s1_kind        <= r_s0_kind;
            r_s1_meta        <= r_s0_meta;
            r_s1_pix         <= r_s0_pix;
            r_s2_req.meta    <= r_s1_meta;
            r_s2_req.fx      <= fx;
            r_s2_req.fy      <= fy;
        end
    end

    bis_locate #(.SIZE_MAX(MAX_SOURCE_WIDTH)) u_locate_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_req.column),
        .i_step  (r_step_horizontal),
        .i_size  (r_source_width),
        .o_lo    (x_lo),
        .o_hi    (x_hi),
        .o_frac  (fx)
    );

    bis_locate #(.SIZE_MAX(MAX_SOURCE_HEIGHT)) u_locate_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (i_req.row),
        .i_step  (r_step_vertical),
        .i_size  (r_source_height),
        .o_lo    (y_lo),
        .o_hi    (y_hi),
        .o_frac  (fy)
    );

    bis_store #(.MAX_W(MAX_SOURCE_WIDTH), .MAX_H(MAX_SOURCE_HEIGHT)) u_store (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_wr      (wr_ok),
        .i_wr_col  (wc32[XW-1:0]),
        .i_wr_row  (wr32[YW-1:0]),
        .i_wr_data (r_s1_pix),
        .i_x_lo    (x_lo),
        .i_x_hi    (x_hi),
        .i_y_lo    (y_lo),
        .i_y_hi    (y_hi),
        .o_texel   (texel)
    );

    bis_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_req   (r_s2_req),
        .i_texel (texel),
        .o_valid (out_valid),
        .o_meta  (out_meta),
        .o_pixel (out_pixel)
    );

    assign o_rsp.valid      = out_valid;
    assign o_rsp.out_column = out_meta.column;
    assign o_rsp.out_row    = out_meta.row;
    assign o_rsp.pixel_out  = out_pixel;

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp.valid)
        else $error("result valid right after reset");

    // The two neighbor indices of a sample are equal or adjacent.
    a_neighbors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_kind == KIND_SAMPLE) |->
        (32'(x_hi) >= 32'(x_lo)) && (32'(x_hi) <= 32'(x_lo) + 32'd1) &&
        (32'(y_hi) >= 32'(y_lo)) && (32'(y_hi) <= 32'(y_lo) + 32'd1))
        else $error("neighbor indices apart by more than one");

    // A stalled result freezes the front of the pipeline.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=>
        $stable(r_s0_valid) && $stable(r_s1_valid) && $stable(r_s2_req.valid))
        else $error("pipeline moved during a stall");

endmodule

// ===== bench/bilinear_image_scaler_tb.sv =====
// Self-checking testbench of the bilinear image scaler.
`timescale 1ns / 1ps

module bilinear_image_scaler_tb;
    import bis_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SRC_MAX     = 256;
    localparam int TGT_MAX     = 1024;

    typedef struct {
        logic                    kind;
        logic [COORD_W-1:0]      column;
        logic [COORD_W-1:0]      row;
        logic signed [PIX_W-1:0] pixel;
    } t_request;

    typedef struct {
        logic [COORD_W-1:0]      column;
        logic [COORD_W-1:0]      row;
        logic signed [PIX_W-1:0] pixel;
    } t_scaled_pixel;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    bis_in_if  req_if ();
    bis_out_if rsp_if ();

    bilinear_image_scaler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #2 i_clk = ~i_clk;

    // Scaler copy: configuration, image store and the results still owed.
    logic [SRC_DIM_W-1:0]    src_w_reg, src_h_reg;
    logic [TGT_DIM_W-1:0]    tgt_w_reg, tgt_h_reg;
    logic [STEP_W-1:0]       step_x_reg, step_y_reg;
    logic signed [PIX_W-1:0] image_store [0:SRC_MAX*SRC_MAX-1];
    bit                      pixel_written [0:SRC_MAX*SRC_MAX-1];

    t_request      pending_requests[$];
    t_scaled_pixel owed_pixels[$];
    t_request      driven_request;

    int errors = 0;
    int requests_taken = 0;
    int pixels_checked = 0;
    int idle_cycles = 0;
    int phase_count = 0;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned max_v);
        return (v == 0) ? 1 : ((v > max_v) ? max_v : v);
    endfunction

    function automatic int unsigned src_w_eff();
        return clamp_dim(src_w_reg, SRC_MAX);
    endfunction
    function automatic int unsigned src_h_eff();
        return clamp_dim(src_h_reg, SRC_MAX);
    endfunction
    function automatic int unsigned tgt_w_eff();
        return (tgt_w_reg > TGT_MAX) ? TGT_MAX : tgt_w_reg;
    endfunction
    function automatic int unsigned tgt_h_eff();
        return (tgt_h_reg > TGT_MAX) ? TGT_MAX : tgt_h_reg;
    endfunction

    // Maps an output coordinate to two clamped source neighbors and the blend weight.
    // The position is kept one pixel up so that it never goes negative.
    function automatic void map_axis(input int unsigned coord, input int unsigned step,
                                     input int unsigned size, output int unsigned lo,
                                     output int unsigned hi, output int unsigned frac);
        longint unsigned pos;
        longint          base;
        pos  = (((longint'(coord) * 2 + 1) * longint'(step)) >> 1) + 32768;
        base = longint'(pos >> 16) - 1;
        frac = 32'(pos & 64'hFFFF);
        lo   = (base < 0) ? 0 : ((base > size - 1) ? size - 1 : 32'(base));
        hi   = (base + 1 > size - 1) ? size - 1 : 32'(base + 1);
    endfunction

    function automatic logic signed [PIX_W-1:0] blend_pixel(int unsigned col, int unsigned row);
        int unsigned x1, x2, y1, y2, fx, fy;
        longint      sum, res;
        map_axis(col, step_x_reg, src_w_eff(), x1, x2, fx);
        map_axis(row, step_y_reg, src_h_eff(), y1, y2, fy);
        sum = (longint'(image_store[y1*SRC_MAX+x1]) * (65536 - fx)
             + longint'(image_store[y1*SRC_MAX+x2]) * fx) * (65536 - fy)
            + (longint'(image_store[y2*SRC_MAX+x1]) * (65536 - fx)
             + longint'(image_store[y2*SRC_MAX+x2]) * fx) * fy;
        // Bias to a non-negative value so the shift rounds ties toward plus infinity.
        res = ((sum + (longint'(32768) << 32) + (longint'(1) << 31)) >>> 32) - 32768;
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return res[PIX_W-1:0];
    endfunction

    function automatic void scale_request(t_request req);
        t_scaled_pixel px;
        if (req.kind == KIND_WRITE) begin
            if (req.column < SRC_MAX && req.row < SRC_MAX)
                image_store[req.row*SRC_MAX + req.column] = req.pixel;
        end else if (req.column < tgt_w_eff() && req.row < tgt_h_eff()) begin
            px.column = req.column;
            px.row    = req.row;
            px.pixel  = blend_pixel(req.column, req.row);
            owed_pixels.push_back(px);
        end
    endfunction

    function automatic void queue_write(int unsigned col, int unsigned row, int pix);
        t_request req;
        req.kind   = KIND_WRITE;
        req.column = COORD_W'(col);
        req.row    = COORD_W'(row);
        req.pixel  = PIX_W'(pix);
        if (col < SRC_MAX && row < SRC_MAX) pixel_written[row*SRC_MAX + col] = 1'b1;
        pending_requests.push_back(req);
    endfunction

    // Queues a sample after writing any of its four neighbors that were never stored.
    function automatic void queue_sample(int unsigned col, int unsigned row);
        t_request    req;
        int unsigned x[2], y[2], fx, fy;
        if (col < tgt_w_eff() && row < tgt_h_eff()) begin
            map_axis(col, step_x_reg, src_w_eff(), x[0], x[1], fx);
            map_axis(row, step_y_reg, src_h_eff(), y[0], y[1], fy);
            foreach (y[j])
                foreach (x[i])
                    if (!pixel_written[y[j]*SRC_MAX + x[i]])
                        queue_write(x[i], y[j], $urandom);
        end
        req.kind   = KIND_SAMPLE;
        req.column = COORD_W'(col);
        req.row    = COORD_W'(row);
        req.pixel  = PIX_W'($urandom);
        pending_requests.push_back(req);
    endfunction

    function automatic int sender_idle_pct();
        return (requests_taken < 220) ? 31 : ((requests_taken < 440) ? 58 : 0);
    endfunction
    function automatic int receiver_idle_pct();
        return (requests_taken < 220) ? 58 : ((requests_taken < 440) ? 31 : 0);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid    <= 1'b0;
            req_if.kind     <= KIND_WRITE;
            req_if.column   <= '0;
            req_if.row      <= '0;
            req_if.pixel_in <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                scale_request(driven_request);
                requests_taken++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    driven_request   = pending_requests.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.kind     <= driven_request.kind;
                    req_if.column   <= driven_request.column;
                    req_if.row      <= driven_request.row;
                    req_if.pixel_in <= driven_request.pixel;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_scaled_pixel exp_px;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (owed_pixels.size() == 0) begin
                    $error("result with nothing owed: column %0d row %0d pixel %0d",
                           rsp_if.out_column, rsp_if.out_row, rsp_if.pixel_out);
                    errors++;
                end else begin
                    exp_px = owed_pixels.pop_front();
                    if (rsp_if.out_column !== exp_px.column) begin
                        $error("out_column: expected %0d, got %0d", exp_px.column,
                               rsp_if.out_column);
                        errors++;
                    end
                    if (rsp_if.out_row !== exp_px.row) begin
                        $error("out_row: expected %0d, got %0d", exp_px.row, rsp_if.out_row);
                        errors++;
                    end
                    if (rsp_if.pixel_out !== exp_px.pixel) begin
                        $error("pixel_out: expected %0d, got %0d", exp_px.pixel,
                               rsp_if.pixel_out);
                        errors++;
                    end
                end
                pixels_checked++;
            end
            rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // The check runs on the falling edge, when every update of the rising edge has settled.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_requests.size() > 0 || req_if.valid || owed_pixels.size() > 0)
            @(negedge i_clk);
        // Writes give no result, so the last one may still be in the pipeline.
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= CFG_DATA_W'(value);
        case (index)
            CFG_SOURCE_WIDTH:    src_w_reg  = SRC_DIM_W'(value);
            CFG_SOURCE_HEIGHT:   src_h_reg  = SRC_DIM_W'(value);
            CFG_TARGET_WIDTH:    tgt_w_reg  = TGT_DIM_W'(value);
            CFG_TARGET_HEIGHT:   tgt_h_reg  = TGT_DIM_W'(value);
            CFG_STEP_HORIZONTAL: step_x_reg = STEP_W'(value);
            default:             step_y_reg = STEP_W'(value);
        endcase
    endtask

    task automatic configure(int unsigned sw, int unsigned sh, int unsigned tw,
                             int unsigned th, int unsigned sx, int unsigned sy);
        wait_drained();
        write_reg(CFG_SOURCE_WIDTH, sw);
        write_reg(CFG_SOURCE_HEIGHT, sh);
        write_reg(CFG_TARGET_WIDTH, tw);
        write_reg(CFG_TARGET_HEIGHT, th);
        write_reg(CFG_STEP_HORIZONTAL, sx);
        write_reg(CFG_STEP_VERTICAL, sy);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        phase_count++;
    endtask

    task automatic random_phase(int unsigned sw, int unsigned sh, int unsigned tw,
                                int unsigned th, int unsigned sx, int unsigned sy, int n);
        int unsigned col, row;
        configure(sw, sh, tw, th, sx, sy);
        repeat (n) begin
            if ($urandom_range(99) < 22) begin
                if ($urandom_range(3) == 0) begin
                    col = $urandom_range(1023);
                    row = $urandom_range(1023);
                end else begin
                    col = $urandom_range(src_w_eff() - 1);
                    row = $urandom_range(src_h_eff() - 1);
                end
                queue_write(col, row, $urandom);
            end else begin
                if (tgt_w_eff() > 0 && tgt_h_eff() > 0 && $urandom_range(9) != 0) begin
                    col = $urandom_range(tgt_w_eff() - 1);
                    row = $urandom_range(tgt_h_eff() - 1);
                end else begin
                    col = $urandom_range(1023);
                    row = $urandom_range(1023);
                end
                queue_sample(col, row);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Halfway horizontal weight: sums of exactly one half in both signs.
        configure(4, 2, 2, 2, 131072, 65536);
        queue_write(0, 0, 0);
        queue_write(1, 0, 1);
        queue_write(0, 1, -1);
        queue_write(1, 1, 0);
        queue_write(2, 0, 32767);
        queue_write(3, 0, -32768);
        queue_write(2, 1, -32768);
        queue_write(3, 1, 32767);
        queue_write(1023, 1023, 12345);
        queue_write(1023, 0, -5);
        queue_write(0, 1023, 7);
        queue_sample(0, 0);
        queue_sample(0, 1);
        queue_sample(1, 0);
        queue_sample(1, 1);
        queue_sample(2, 0);
        queue_sample(0, 2);
        queue_sample(1023, 1023);

        random_phase(8, 8, 16, 16, 32768, 32768, 40);
        random_phase(16, 12, 5, 7, 16 * 65536 / 5, 12 * 65536 / 7, 40);
        random_phase(256, 256, 1024, 1024, 16384, 16384, 30);
        // Source sizes outside their range, target above the maximum, extreme steps.
        random_phase(0, 511, 2047, 3, 1, 16777216, 30);
        random_phase(1, 1, 1, 1, 65536, 65536, 15);
        // A zero target width leaves every sample without a result.
        random_phase(3, 256, 0, 9, 65536, 65536, 15);
        random_phase(10, 10, 13, 9, 10 * 65536 / 13, 10 * 65536 / 9, 60);
        random_phase(256, 256, 256, 256, 65536, 65536, 40);

        wait_drained();
        $display("Ran %0d configurations: %0d requests taken, %0d scaled pixels checked.",
                 phase_count, requests_taken, pixels_checked);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
